### rtl/core/bbfa_pkg.sv
package bbfa_pkg;

    // Block geometry. BLOCK_BYTES is a power of two and NUM_BLOCKS a multiple of MAP_WORD.
    localparam int NUM_BLOCKS      = 1024;
    localparam int BLOCK_BYTES     = 64;
    localparam int RESERVED_BLOCKS = 2;
    localparam int HEADER_BYTES    = 4;

    localparam int ADDR_W      = 32;
    localparam int BYTES_W     = 17;
    localparam int BLK_W       = $clog2(NUM_BLOCKS);
    localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int SUM_W       = BYTES_W + 1;

    localparam int MAP_WORD  = 8;
    localparam int BIT_W     = $clog2(MAP_WORD);
    localparam int MAP_DEPTH = NUM_BLOCKS / MAP_WORD;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    localparam int S_DATA_W = ((BYTES_W + ADDR_W + 7) / 8) * 8;
    localparam int M_DATA_W = ADDR_W;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STAT_DONE    = 1'b0;
    localparam logic STAT_REFUSED = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_CLOSE,
        ST_FREE_CHK,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
    } scan_ctl_t;

    typedef struct packed {
        logic             found;
        logic [BLK_W-1:0] best_start;
    } scan_res_t;

    function automatic logic [MAP_WORD-1:0] reset_row(input logic [MAP_AW-1:0] row);
        logic [MAP_WORD-1:0] bits;
        bits = '0;
        for (int b = 0; b < MAP_WORD; b++)
        begin
            bits[b] = ((int'(row) * MAP_WORD + b) < RESERVED_BLOCKS);
        end
        return bits;
    endfunction

endpackage

### rtl/core/bbfa_ram.sv
module bbfa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/bbfa_scan.sv
module bbfa_scan (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bbfa_pkg::scan_ctl_t          ctl,
    input  logic [bbfa_pkg::CNT_W-1:0]   need,
    input  logic [bbfa_pkg::MAP_WORD-1:0] word,
    input  logic [bbfa_pkg::MAP_AW-1:0]  word_idx,
    output bbfa_pkg::scan_res_t          res
);
    import bbfa_pkg::*;

    logic [CNT_W-1:0] run_reg, run_next;
    logic [CNT_W-1:0] best_len_reg, best_len_next;
    logic [BLK_W-1:0] best_start_reg, best_start_next;
    logic             found_reg, found_next;
    logic             take_last;

    // Walks the eight blocks of one map word, tracking the current free run and the best fit.
    always_comb
    begin
        logic [CNT_W-1:0] run;
        logic [CNT_W-1:0] best_len;
        logic [BLK_W-1:0] best_start;
        logic             found;
        logic [CNT_W-1:0] pos;
        run        = run_reg;
        best_len   = best_len_reg;
        best_start = best_start_reg;
        found      = found_reg;
        pos        = '0;
        if (ctl.start)
        begin
            run   = '0;
            found = 1'b0;
        end
        else if (ctl.step)
        begin
            for (int b = 0; b < MAP_WORD; b++)
            begin
                pos = CNT_W'({word_idx, BIT_W'(b)});
                if (word[b])
                begin
                    if (run >= need && (!found || run < best_len))
                    begin
                        found      = 1'b1;
                        best_len   = run;
                        best_start = BLK_W'(pos - run);
                    end
                    run = '0;
                end
                else
                begin
                    run = run + CNT_W'(1);
                end
            end
        end
        run_next        = run;
        best_len_next   = best_len;
        best_start_next = best_start;
        found_next      = found;
    end

    // The end of the map closes the trailing run as if a used block followed it.
    assign take_last = (run_reg >= need) && (!found_reg || run_reg < best_len_reg);

    always_comb
    begin
        res.found      = found_reg | take_last;
        res.best_start = take_last ? BLK_W'(CNT_W'(NUM_BLOCKS) - run_reg) : best_start_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg        <= '0;
            best_len_reg   <= '0;
            best_start_reg <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            run_reg        <= run_next;
            best_len_reg   <= best_len_next;
            best_start_reg <= best_start_next;
            found_reg      <= found_next;
        end
    end

endmodule

### rtl/core/bitmap_best_fit_allocator_top.sv
// Allocate: full scan of the used map, a close step, then marking of each touched map word.
// The sequential read of the used map, one 8-block word per cycle, sets the scan time.
// Free: a check of the stored run length, then marking reads and writes back each touched map word.
// One request is in work at a time; a result waits in the output register while the next is taken.
// After reset a clearing pass over NUM_BLOCKS indices (1024) rewrites both RAMs before requests flow.
// Reset is asynchronous and active low; the base address resets to zero.
module bitmap_best_fit_allocator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bbfa_pkg::S_DATA_W-1:0]  s_tdata,  // request_bytes, free_address, zero fill
    input  logic                           s_tuser,  // operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bbfa_pkg::M_DATA_W-1:0]  m_tdata,  // granted_address
    output logic                           m_tuser,  // status
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bbfa_pkg::ADDR_W-1:0]    cfg_data
);
    import bbfa_pkg::*;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]   base_reg;
    logic [CNT_W-1:0]    need_reg, need_next;
    logic [MAP_AW:0]     scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]    cur_reg, cur_next;
    logic [CNT_W-1:0]    end_reg, end_next;
    logic                set_mode_reg, set_mode_next;
    logic [BLK_W-1:0]    idx_reg, idx_next;
    logic [BLK_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic                res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic                out_status_reg, out_status_next;

    logic                map_we, map_re;
    logic [MAP_AW-1:0]   map_waddr, map_raddr;
    logic [MAP_WORD-1:0] map_wdata, map_rdata;
    logic                len_we, len_re;
    logic [BLK_W-1:0]    len_waddr, len_raddr;
    logic [CNT_W-1:0]    len_wdata, len_rdata;

    scan_ctl_t           scan_ctl;
    scan_res_t           scan_res;

    logic                accept;
    logic [SUM_W-1:0]    need_full;
    logic                alloc_ok;
    logic [ADDR_W-1:0]   free_off;
    logic                free_ok;
    logic [BLK_W-1:0]    free_idx;
    logic                scan_last;
    logic                resp_load;
    logic [MAP_AW-1:0]   mark_row;
    logic [MAP_WORD-1:0] mark_mask;
    logic [CNT_W-1:0]    mark_next_cur;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign need_full = (SUM_W'(s_tdata[BYTES_W-1:0]) + SUM_W'(HEADER_BYTES + BLOCK_BYTES - 1))
                       >> BLOCK_SHIFT;
    assign alloc_ok  = (s_tdata[BYTES_W-1:0] != '0) && (need_full <= SUM_W'(NUM_BLOCKS));

    assign free_off  = s_tdata[BYTES_W +: ADDR_W] - ADDR_W'(HEADER_BYTES) - base_reg;
    assign free_ok   = (free_off[BLOCK_SHIFT-1:0] == '0)
                       && ((free_off >> BLOCK_SHIFT) < ADDR_W'(NUM_BLOCKS));
    assign free_idx  = free_off[BLOCK_SHIFT +: BLK_W];

    assign scan_last = (scan_cnt_reg == (MAP_AW + 1)'(MAP_DEPTH));
    assign resp_load = (state_reg == ST_RESP) && (!out_valid_reg || m_tready);

    assign mark_row      = cur_reg[BLK_W-1:BIT_W];
    assign mark_next_cur = CNT_W'({mark_row, BIT_W'(0)}) + CNT_W'(MAP_WORD);

    always_comb
    begin
        logic [CNT_W-1:0] pos;
        pos = '0;
        for (int b = 0; b < MAP_WORD; b++)
        begin
            pos          = CNT_W'({mark_row, BIT_W'(b)});
            mark_mask[b] = (pos >= cur_reg) && (pos < end_reg);
        end
    end

    bbfa_ram #(
        .DEPTH (MAP_DEPTH),
        .WIDTH (MAP_WORD)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    bbfa_ram #(
        .DEPTH (NUM_BLOCKS),
        .WIDTH (CNT_W)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    bbfa_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .need     (need_reg),
        .word     (map_rdata),
        .word_idx (MAP_AW'(scan_cnt_reg - (MAP_AW + 1)'(1))),
        .res      (scan_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == BLK_W'(NUM_BLOCKS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == OP_FREE)
                    begin
                        state_next = free_ok ? ST_FREE_CHK : ST_RESP;
                    end
                    else
                    begin
                        state_next = alloc_ok ? ST_SCAN : ST_RESP;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                state_next = scan_res.found ? ST_MARK_RD : ST_RESP;
            end
            ST_FREE_CHK:
            begin
                state_next = (len_rdata != '0) ? ST_MARK_RD : ST_RESP;
            end
            ST_MARK_RD:
            begin
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR:
            begin
                state_next = (mark_next_cur >= end_reg) ? ST_RESP : ST_MARK_RD;
            end
            ST_RESP:
            begin
                if (resp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = 1'b0;
        map_we         = 1'b0;
        map_waddr      = mark_row;
        map_wdata      = set_mode_reg ? (map_rdata | mark_mask) : (map_rdata & ~mark_mask);
        map_re         = 1'b0;
        map_raddr      = mark_row;
        len_we         = 1'b0;
        len_waddr      = idx_reg;
        len_wdata      = '0;
        len_re         = 1'b0;
        len_raddr      = free_idx;
        scan_ctl.start = 1'b0;
        scan_ctl.step  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                len_we    = 1'b1;
                len_waddr = clr_cnt_reg;
                map_we    = (CNT_W'(clr_cnt_reg) < CNT_W'(MAP_DEPTH));
                map_waddr = clr_cnt_reg[MAP_AW-1:0];
                map_wdata = reset_row(clr_cnt_reg[MAP_AW-1:0]);
            end
            ST_IDLE:
            begin
                s_tready       = 1'b1;
                len_re         = accept && (s_tuser == OP_FREE);
                scan_ctl.start = 1'b1;
            end
            ST_SCAN:
            begin
                map_re        = !scan_last;
                map_raddr     = scan_cnt_reg[MAP_AW-1:0];
                scan_ctl.step = (scan_cnt_reg != '0);
            end
            ST_CLOSE:
            begin
                len_we    = scan_res.found;
                len_waddr = scan_res.best_start;
                len_wdata = need_reg;
            end
            ST_FREE_CHK:
            begin
                len_we = (len_rdata != '0);
            end
            ST_MARK_RD:
            begin
                map_re = 1'b1;
            end
            ST_MARK_WR:
            begin
                map_we = 1'b1;
            end
            ST_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        need_next       = need_reg;
        scan_cnt_next   = scan_cnt_reg;
        cur_next        = cur_reg;
        end_next        = end_reg;
        set_mode_next   = set_mode_reg;
        idx_next        = idx_reg;
        clr_cnt_next    = clr_cnt_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (resp_load)
        begin
            out_valid_next  = 1'b1;
            out_addr_next   = res_addr_reg;
            out_status_next = res_status_reg;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + BLK_W'(1);
            end
            ST_IDLE:
            begin
                res_addr_next   = '0;
                res_status_next = STAT_REFUSED;
                scan_cnt_next   = '0;
                need_next       = CNT_W'(need_full);
                idx_next        = free_idx;
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + (MAP_AW + 1)'(1);
            end
            ST_CLOSE:
            begin
                cur_next      = CNT_W'(scan_res.best_start);
                end_next      = CNT_W'(scan_res.best_start) + need_reg;
                set_mode_next = 1'b1;
                if (scan_res.found)
                begin
                    res_addr_next   = base_reg + (ADDR_W'(scan_res.best_start) << BLOCK_SHIFT)
                                      + ADDR_W'(HEADER_BYTES);
                    res_status_next = STAT_DONE;
                end
            end
            ST_FREE_CHK:
            begin
                cur_next      = CNT_W'(idx_reg);
                end_next      = CNT_W'(idx_reg) + len_rdata;
                set_mode_next = 1'b0;
                if (len_rdata != '0)
                begin
                    res_status_next = STAT_DONE;
                end
            end
            ST_MARK_WR:
            begin
                cur_next = mark_next_cur;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            base_reg      <= '0;
            clr_cnt_reg   <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg       <= need_next;
        cur_reg        <= cur_next;
        end_reg        <= end_next;
        set_mode_reg   <= set_mode_next;
        idx_reg        <= idx_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    a_scan_need: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> need_reg != '0 && need_reg <= CNT_W'(NUM_BLOCKS))
        else $error("scan running with an out-of-range block count");

    a_mark_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MARK_RD |-> cur_reg < end_reg && end_reg <= CNT_W'(NUM_BLOCKS))
        else $error("mark pass outside the block map");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == STAT_REFUSED |-> out_addr_reg == '0)
        else $error("refused result carries a nonzero address");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");
`endif

endmodule

### sim/allocator_checker.sv
module allocator_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [bbfa_pkg::S_DATA_W-1:0] s_tdata,  // request_bytes, free_address, zero fill
    input  logic                          s_tuser,  // operation
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [bbfa_pkg::M_DATA_W-1:0] m_tdata,  // granted_address
    input  logic                          m_tuser,  // status
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [bbfa_pkg::ADDR_W-1:0]   cfg_data,
    output int unsigned                   fail_count,
    output int unsigned                   results_owed
);
    timeunit 1ns;
    timeprecision 1ps;
    import bbfa_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              status;
    } grant_t;

    bit                block_used [NUM_BLOCKS];
    int unsigned       run_blocks [NUM_BLOCKS];
    logic [ADDR_W-1:0] base_address;
    grant_t            pending_grants [$];
    grant_t            oldest;

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        fail_count++;
        if (fail_count <= 100)
        begin
            $display("mismatch at %0t: %s, got %h, expected %h", $time, what, got, want);
        end
    endtask

    // The smallest free run that fits wins; the end of the map closes the last run.
    function automatic grant_t predict_allocate(input logic [BYTES_W-1:0] bytes);
        grant_t      r;
        int unsigned need;
        int unsigned run;
        int unsigned best_start;
        int unsigned best_len;
        bit          found;
        r.addr = '0;
        r.status = STAT_REFUSED;
        if (bytes == '0)
        begin
            return r;
        end
        need = (int'(bytes) + HEADER_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
        if (need > NUM_BLOCKS)
        begin
            return r;
        end
        run = 0;
        best_start = 0;
        best_len = 0;
        found = 1'b0;
        for (int i = 0; i <= NUM_BLOCKS; i++)
        begin
            if (i == NUM_BLOCKS || block_used[i])
            begin
                if (run >= need && (!found || run < best_len))
                begin
                    found = 1'b1;
                    best_len = run;
                    best_start = i - run;
                end
                run = 0;
            end
            else
            begin
                run++;
            end
        end
        if (!found)
        begin
            return r;
        end
        for (int i = 0; i < need; i++)
        begin
            block_used[best_start + i] = 1'b1;
        end
        run_blocks[best_start] = need;
        r.addr = base_address + ADDR_W'(best_start * BLOCK_BYTES) + ADDR_W'(HEADER_BYTES);
        r.status = STAT_DONE;
        return r;
    endfunction

    function automatic grant_t predict_release(input logic [ADDR_W-1:0] addr);
        grant_t            r;
        logic [ADDR_W-1:0] offset;
        int unsigned       first;
        r.addr = '0;
        r.status = STAT_REFUSED;
        offset = addr - ADDR_W'(HEADER_BYTES) - base_address;
        if (offset % BLOCK_BYTES != 0)
        begin
            return r;
        end
        if (offset / BLOCK_BYTES >= NUM_BLOCKS)
        begin
            return r;
        end
        first = offset / BLOCK_BYTES;
        if (run_blocks[first] == 0)
        begin
            return r;
        end
        for (int i = 0; i < run_blocks[first] && first + i < NUM_BLOCKS; i++)
        begin
            block_used[first + i] = 1'b0;
        end
        run_blocks[first] = 0;
        r.status = STAT_DONE;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            base_address = '0;
            pending_grants.delete();
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                block_used[i] = (i < RESERVED_BLOCKS);
                run_blocks[i] = 0;
            end
            results_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_address = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_grants.size() == 0)
                begin
                    report_mismatch("result with no request waiting", m_tdata, '0);
                end
                else
                begin
                    oldest = pending_grants.pop_front();
                    if (m_tdata !== oldest.addr)
                    begin
                        report_mismatch("granted_address", m_tdata, oldest.addr);
                    end
                    if (m_tuser !== oldest.status)
                    begin
                        report_mismatch("status", ADDR_W'(m_tuser), ADDR_W'(oldest.status));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_ALLOC)
                begin
                    pending_grants.push_back(predict_allocate(s_tdata[BYTES_W-1:0]));
                end
                else
                begin
                    pending_grants.push_back(predict_release(s_tdata[BYTES_W +: ADDR_W]));
                end
            end
            results_owed <= pending_grants.size();
        end
    end

endmodule

### sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bbfa_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;  // request_bytes, free_address, zero fill
    logic                s_tuser = OP_ALLOC;  // operation
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;  // granted_address
    logic                m_tuser;  // status
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [ADDR_W-1:0]   cfg_data = '0;
    int unsigned         fail_count;
    int unsigned         results_owed;

    logic [ADDR_W-1:0]   base_now = '0;
    logic [ADDR_W-1:0]   live_offsets [$];
    logic [ADDR_W-1:0]   freed_offsets [$];
    logic                ops_in_flight [$];
    int                  burst_left = 0;
    int                  stall_mode = 0;
    int                  stall_count = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bitmap_best_fit_allocator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    allocator_checker grant_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .results_owed(results_owed)
    );

    // The receiver switches between always ready, random stalls, rare stalls and a square wave.
    always @(posedge clk)
    begin
        if (stall_count == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_count <= $urandom_range(50, 400);
        end
        else
        begin
            stall_count <= stall_count - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 7) != 0);
            default: m_tready <= stall_count[4];
        endcase
    end

    // Granted runs are remembered relative to the base so that they can be freed later.
    always @(posedge clk)
    begin : track_grants
        logic op;
        if (m_tvalid && m_tready && ops_in_flight.size() != 0)
        begin
            op = ops_in_flight.pop_front();
            if (op == OP_ALLOC && m_tuser == STAT_DONE)
            begin
                live_offsets.push_back(m_tdata - base_now);
            end
        end
        if (s_tvalid && s_tready)
        begin
            ops_in_flight.push_back(s_tuser);
        end
    end

    task automatic send_request(input logic op, input logic [BYTES_W-1:0] bytes,
                                input logic [ADDR_W-1:0] addr);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{(S_DATA_W - BYTES_W - ADDR_W){1'b0}}, addr, bytes};
        do @(posedge clk); while (s_tready !== 1'b1);
        burst_left--;
    endtask

    task automatic send_alloc(input logic [BYTES_W-1:0] bytes);
        send_request(OP_ALLOC, bytes, $urandom());
    endtask

    task automatic send_free(input logic [ADDR_W-1:0] addr);
        send_request(OP_FREE, BYTES_W'($urandom_range(0, 65536)), addr);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        base_now = value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] block_addr(input int unsigned blk);
        return base_now + ADDR_W'(HEADER_BYTES) + ADDR_W'(blk * BLOCK_BYTES);
    endfunction

    // Mostly small requests keep the map fragmented; a few span most of the region.
    function automatic logic [BYTES_W-1:0] random_bytes();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)
        begin
            return '0;
        end
        if (pick < 70)
        begin
            return BYTES_W'($urandom_range(1, 300));
        end
        if (pick < 88)
        begin
            return BYTES_W'($urandom_range(301, 4000));
        end
        if (pick < 96)
        begin
            return BYTES_W'($urandom_range(4001, 20000));
        end
        if (pick < 99)
        begin
            return BYTES_W'($urandom_range(20001, 65535));
        end
        return BYTES_W'($urandom_range(65500, 65536));
    endfunction

    task automatic random_item();
        int                pick;
        int                k;
        logic [ADDR_W-1:0] off;
        pick = $urandom_range(0, 99);
        if (pick < 50 || live_offsets.size() == 0)
        begin
            send_alloc(random_bytes());
        end
        else if (pick < 88)
        begin
            k = $urandom_range(0, live_offsets.size() - 1);
            off = live_offsets[k];
            live_offsets.delete(k);
            freed_offsets.push_back(off);
            if (freed_offsets.size() > 32)
            begin
                void'(freed_offsets.pop_front());
            end
            send_free(base_now + off);
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: send_free($urandom());
                1:
                begin
                    if (freed_offsets.size() != 0)
                    begin
                        k = $urandom_range(0, freed_offsets.size() - 1);
                        send_free(base_now + freed_offsets[k]);
                    end
                    else
                    begin
                        send_free($urandom());
                    end
                end
                2: send_free(block_addr($urandom_range(0, NUM_BLOCKS - 1))
                             + ADDR_W'($urandom_range(1, BLOCK_BYTES - 1)));
                3: send_free(block_addr($urandom_range(0, RESERVED_BLOCKS - 1)));
                4: send_free(block_addr($urandom_range(NUM_BLOCKS, NUM_BLOCKS + 1000)));
                default: send_alloc('0);
            endcase
        end
    endtask

    initial
    begin
        logic [ADDR_W-1:0] phase_bases [6];
        phase_bases[0] = 32'h0000_0000;
        phase_bases[1] = 32'hFFFF_FFFF;
        phase_bases[2] = 32'h7FFF_FFFF;
        phase_bases[3] = 32'hFFFF_FF7C;
        phase_bases[4] = $urandom();
        phase_bases[5] = 32'h0000_1000;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_base(32'h0000_0000);

        send_alloc('0);
        send_alloc(BYTES_W'(1));
        send_alloc(BYTES_W'(BLOCK_BYTES - HEADER_BYTES));
        send_alloc(BYTES_W'(BLOCK_BYTES - HEADER_BYTES + 1));
        send_alloc(BYTES_W'(65536));
        send_alloc(BYTES_W'(NUM_BLOCKS * BLOCK_BYTES - HEADER_BYTES));
        send_free(block_addr(2));
        send_alloc(BYTES_W'(1));
        send_free(block_addr(4));
        send_free(block_addr(3));
        send_alloc(BYTES_W'(100));
        send_alloc(BYTES_W'(1));
        repeat (4) send_alloc(BYTES_W'(1));
        send_free(block_addr(6));
        send_free(block_addr(8));
        // Two equal holes: the earlier one must be taken.
        send_alloc(BYTES_W'(1));
        send_free(block_addr(8));
        send_free(block_addr(2) + 1);
        send_free(block_addr(0));
        send_free(block_addr(NUM_BLOCKS));
        // This request fills the trailing run exactly, leaving only the one-block hole.
        send_alloc(BYTES_W'((NUM_BLOCKS - 10) * BLOCK_BYTES - HEADER_BYTES));
        send_alloc(BYTES_W'(1));
        send_alloc(BYTES_W'(1));
        send_free(block_addr(10));
        wait_for_results();

        foreach (phase_bases[p])
        begin
            write_base(phase_bases[p]);
            repeat (305)
            begin
                random_item();
                if ($urandom_range(0, 99) == 0)
                begin
                    wait_for_results();
                end
            end
            wait_for_results();
        end

        repeat (600) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
